/* rtl/core/fpsm_pkg.sv */
// Shared widths, codes and constants of the frame pipeline statistics monitor.
// No dependencies; used by frame_pipeline_stats_monitor_core.
`default_nettype none

package fpsm_pkg;

  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned LAT_W   = 24;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned US_PER_SECOND = 1000000;
  localparam int unsigned US_W = $clog2(US_PER_SECOND + 1);

  // dividend width of the shared divider: fits a frame count times US_PER_SECOND
  localparam int unsigned DIVD_W = SEQ_W + US_W;
  localparam int unsigned DCNT_W = $clog2(DIVD_W + 1);

  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [LAT_W-1:0]  LAT_MAX   = '1;
  localparam logic [31:0]       INTERVAL_RESET = 32'd1000000;

  // item kinds
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

  // division jobs of one report, in running order
  localparam logic [2:0] JOB_CAP_RATE = 3'd0;
  localparam logic [2:0] JOB_ENC_RATE = 3'd1;
  localparam logic [2:0] JOB_WAIT_AVG = 3'd2;
  localparam logic [2:0] JOB_CONV_AVG = 3'd3;
  localparam logic [2:0] JOB_ENC_AVG  = 3'd4;

endpackage

`default_nettype wire

/* rtl/core/frame_pipeline_stats_monitor_core.sv */
// Frame pipeline statistics monitor: frame event counting and periodic reports.
// Depends on fpsm_pkg (widths, codes, constants) by scoped names.
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// in_       | in_valid / in_ready  | cmd, frame_seq, 3 latencies, now_us, seq
// out_      | out_valid / out_ready| rates, counts, averages, peak, last seq
// cfg_      | cfg_wr_en            | cfg_index, cfg_wdata (32 bits)
//
// A frame item, a disabled item, a first check or a check that is not yet due
// is handled without a division. A due report runs a check state, five divisions
// (load, 52 steps, store; the steps are skipped for a zero divisor) on one shared
// restoring divider, and a closing state, with in_ready low throughout.
// Reset (rst_n low, synchronous) restores enable and interval to defaults and
// clears all statistics. A pending result does not block frame items, but a due
// report waits, with the input held, until the previous result has been taken.

module frame_pipeline_stats_monitor_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [fpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpsm_pkg::CFG_W-1:0]    cfg_wdata,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [fpsm_pkg::SEQ_W-1:0]    in_frame_seq,
  input  wire logic [fpsm_pkg::LAT_W-1:0]    in_wait_us,
  input  wire logic [fpsm_pkg::LAT_W-1:0]    in_convert_us,
  input  wire logic [fpsm_pkg::LAT_W-1:0]    in_encode_us,
  input  wire logic [fpsm_pkg::TIME_W-1:0]   in_now_us,
  input  wire logic [fpsm_pkg::SEQ_W-1:0]    in_captured_seq,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fpsm_pkg::CNT_W-1:0]         out_capture_rate,
  output logic [fpsm_pkg::CNT_W-1:0]         out_encode_rate,
  output logic [fpsm_pkg::CNT_W-1:0]         out_captured_frames,
  output logic [fpsm_pkg::CNT_W-1:0]         out_encoded_frames,
  output logic [fpsm_pkg::CNT_W-1:0]         out_duplicate_frames,
  output logic [fpsm_pkg::CNT_W-1:0]         out_skipped_frames,
  output logic [fpsm_pkg::LAT_W-1:0]         out_wait_avg_us,
  output logic [fpsm_pkg::LAT_W-1:0]         out_wait_peak_us,
  output logic [fpsm_pkg::LAT_W-1:0]         out_convert_avg_us,
  output logic [fpsm_pkg::LAT_W-1:0]         out_encode_avg_us,
  output logic [fpsm_pkg::SEQ_W-1:0]         out_latest_encoded_seq
);

  localparam int unsigned SEQ_W  = fpsm_pkg::SEQ_W;
  localparam int unsigned LAT_W  = fpsm_pkg::LAT_W;
  localparam int unsigned TIME_W = fpsm_pkg::TIME_W;
  localparam int unsigned CNT_W  = fpsm_pkg::CNT_W;
  localparam int unsigned SUM_W  = fpsm_pkg::SUM_W;
  localparam int unsigned DIVD_W = fpsm_pkg::DIVD_W;
  localparam int unsigned DCNT_W = fpsm_pkg::DCNT_W;

  localparam logic [DIVD_W-1:0] US_MULT = DIVD_W'(fpsm_pkg::US_PER_SECOND);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // configuration
  logic                 enable_r;
  logic [31:0]          interval_r;

  // statistics state
  logic                 started_r;
  logic [TIME_W-1:0]    interval_start_r;
  logic [SEQ_W-1:0]     prev_cap_seq_r;
  logic                 have_encoded_r;
  logic [SEQ_W-1:0]     prev_enc_seq_r;
  logic [CNT_W-1:0]     encoded_count_r;
  logic [CNT_W-1:0]     dup_count_r;
  logic [CNT_W-1:0]     skip_count_r;
  logic [SUM_W-1:0]     wait_sum_r;
  logic [LAT_W-1:0]     wait_max_r;
  logic [SUM_W-1:0]     conv_sum_r;
  logic [SUM_W-1:0]     enc_sum_r;

  // sequencer and check item
  logic [2:0]           state_r;
  logic [2:0]           job_r;
  logic [TIME_W-1:0]    now_r;
  logic [SEQ_W-1:0]     cap_r;
  logic [TIME_W-1:0]    elapsed_r;

  // shared divider: dividend shifts out of dq_r as quotient bits shift in
  logic [DIVD_W-1:0]    dq_r;
  logic [TIME_W-1:0]    rem_r;
  logic [TIME_W-1:0]    divisor_r;
  logic [DCNT_W-1:0]    dcnt_r;

  // output register
  logic                 out_valid_r;
  logic [CNT_W-1:0]     out_cap_rate_r;
  logic [CNT_W-1:0]     out_enc_rate_r;
  logic [CNT_W-1:0]     out_cap_frames_r;
  logic [CNT_W-1:0]     out_enc_frames_r;
  logic [CNT_W-1:0]     out_dup_frames_r;
  logic [CNT_W-1:0]     out_skip_frames_r;
  logic [LAT_W-1:0]     out_wait_avg_r;
  logic [LAT_W-1:0]     out_wait_peak_r;
  logic [LAT_W-1:0]     out_conv_avg_r;
  logic [LAT_W-1:0]     out_enc_avg_r;
  logic [SEQ_W-1:0]     out_last_seq_r;

  logic                 in_fire;
  logic                 out_fire;

  // frame item arithmetic
  logic [SEQ_W-1:0]     seq_diff;
  logic                 seq_dup;
  logic                 seq_skip;
  logic [CNT_W:0]       skip_sum;
  logic [SUM_W:0]       wait_sum_ext;
  logic [SUM_W:0]       conv_sum_ext;
  logic [SUM_W:0]       enc_sum_ext;

  // divider step and operand selection
  logic [TIME_W:0]      rem_shift;
  logic                 div_ge;
  logic [TIME_W:0]      rem_diff;
  logic [DIVD_W-1:0]    load_dividend;
  logic [TIME_W-1:0]    load_divisor;
  logic [CNT_W-1:0]     mult_a;
  logic                 q_over_cnt;
  logic                 q_over_lat;
  logic [CNT_W-1:0]     q_cnt;
  logic [LAT_W-1:0]     q_lat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // ---- frame item: duplicate / skip detection and saturating sums ----
  assign seq_diff = in_frame_seq - prev_enc_seq_r;
  assign seq_dup  = have_encoded_r && (in_frame_seq == prev_enc_seq_r);
  // forward jump of two or more
  assign seq_skip = have_encoded_r && (in_frame_seq > prev_enc_seq_r) &&
                    (seq_diff > SEQ_W'(1));
  assign skip_sum = {1'b0, skip_count_r} + {1'b0, seq_diff - SEQ_W'(1)};

  assign wait_sum_ext = {1'b0, wait_sum_r} + (SUM_W + 1)'(in_wait_us);
  assign conv_sum_ext = {1'b0, conv_sum_r} + (SUM_W + 1)'(in_convert_us);
  assign enc_sum_ext  = {1'b0, enc_sum_r}  + (SUM_W + 1)'(in_encode_us);

  // ---- shared divider, one quotient bit per cycle ----
  assign rem_shift = {rem_r, dq_r[DIVD_W-1]};
  assign div_ge    = rem_shift >= {1'b0, divisor_r};
  assign rem_diff  = rem_shift - {1'b0, divisor_r};

  // rates divide frames * 1e6 by elapsed time; averages divide sums by count
  assign mult_a = (job_r == fpsm_pkg::JOB_CAP_RATE) ? out_cap_frames_r : encoded_count_r;

  always_comb begin
    case (job_r)
      fpsm_pkg::JOB_CAP_RATE, fpsm_pkg::JOB_ENC_RATE: begin
        load_dividend = DIVD_W'(mult_a) * US_MULT;
        load_divisor  = elapsed_r;
      end
      fpsm_pkg::JOB_WAIT_AVG: begin
        load_dividend = DIVD_W'(wait_sum_r);
        load_divisor  = TIME_W'(encoded_count_r);
      end
      fpsm_pkg::JOB_CONV_AVG: begin
        load_dividend = DIVD_W'(conv_sum_r);
        load_divisor  = TIME_W'(encoded_count_r);
      end
      default: begin
        load_dividend = DIVD_W'(enc_sum_r);
        load_divisor  = TIME_W'(encoded_count_r);
      end
    endcase
  end

  // clamp the finished quotient to the result width
  assign q_over_cnt = |dq_r[DIVD_W-1:CNT_W];
  assign q_over_lat = |dq_r[DIVD_W-1:LAT_W];
  assign q_cnt      = q_over_cnt ? fpsm_pkg::CNT_MAX : dq_r[CNT_W-1:0];
  assign q_lat      = q_over_lat ? fpsm_pkg::LAT_MAX : dq_r[LAT_W-1:0];

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      interval_r <= fpsm_pkg::INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fpsm_pkg::CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        fpsm_pkg::CFG_INTERVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- sequencer, statistics and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      job_r            <= fpsm_pkg::JOB_CAP_RATE;
      out_valid_r      <= 1'b0;
      started_r        <= 1'b0;
      interval_start_r <= '0;
      prev_cap_seq_r   <= '0;
      have_encoded_r   <= 1'b0;
      prev_enc_seq_r   <= '0;
      encoded_count_r  <= '0;
      dup_count_r      <= '0;
      skip_count_r     <= '0;
      wait_sum_r       <= '0;
      wait_max_r       <= '0;
      conv_sum_r       <= '0;
      enc_sum_r        <= '0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && enable_r) begin
            if (in_cmd == fpsm_pkg::CMD_FRAME) begin
              if (seq_dup && (dup_count_r != fpsm_pkg::CNT_MAX)) begin
                dup_count_r <= dup_count_r + CNT_W'(1);
              end
              if (seq_skip) begin
                skip_count_r <= skip_sum[CNT_W] ? fpsm_pkg::CNT_MAX : skip_sum[CNT_W-1:0];
              end
              have_encoded_r <= 1'b1;
              prev_enc_seq_r <= in_frame_seq;
              if (encoded_count_r != fpsm_pkg::CNT_MAX) begin
                encoded_count_r <= encoded_count_r + CNT_W'(1);
              end
              wait_sum_r <= wait_sum_ext[SUM_W] ? fpsm_pkg::SUM_MAX : wait_sum_ext[SUM_W-1:0];
              conv_sum_r <= conv_sum_ext[SUM_W] ? fpsm_pkg::SUM_MAX : conv_sum_ext[SUM_W-1:0];
              enc_sum_r  <= enc_sum_ext[SUM_W]  ? fpsm_pkg::SUM_MAX : enc_sum_ext[SUM_W-1:0];
              if (in_wait_us > wait_max_r) begin
                wait_max_r <= in_wait_us;
              end
            end else begin
              now_r     <= in_now_us;
              cap_r     <= in_captured_seq;
              elapsed_r <= in_now_us - interval_start_r;
              state_r   <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (!started_r) begin
            // first check: align time base, open a fresh interval
            started_r        <= 1'b1;
            interval_start_r <= now_r;
            prev_cap_seq_r   <= cap_r;
            encoded_count_r  <= '0;
            dup_count_r      <= '0;
            skip_count_r     <= '0;
            wait_sum_r       <= '0;
            wait_max_r       <= '0;
            conv_sum_r       <= '0;
            enc_sum_r        <= '0;
            state_r          <= S_IDLE;
          end else if (elapsed_r < TIME_W'(interval_r)) begin
            state_r <= S_IDLE;
          end else if (!out_valid_r) begin
            // due; previous result gone, so the output register is free
            out_cap_frames_r <= (cap_r > prev_cap_seq_r) ? cap_r - prev_cap_seq_r : '0;
            job_r            <= fpsm_pkg::JOB_CAP_RATE;
            state_r          <= S_LOAD;
          end
        end

        S_LOAD: begin
          divisor_r <= load_divisor;
          rem_r     <= '0;
          dcnt_r    <= DCNT_W'(DIVD_W);
          if (load_divisor == '0) begin
            dq_r    <= '0;
            state_r <= S_STORE;
          end else begin
            dq_r    <= load_dividend;
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r  <= div_ge ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
          dq_r   <= {dq_r[DIVD_W-2:0], div_ge};
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_r <= S_STORE;
          end
        end

        S_STORE: begin
          case (job_r)
            fpsm_pkg::JOB_CAP_RATE: out_cap_rate_r <= q_cnt;
            fpsm_pkg::JOB_ENC_RATE: out_enc_rate_r <= q_cnt;
            fpsm_pkg::JOB_WAIT_AVG: out_wait_avg_r <= q_lat;
            fpsm_pkg::JOB_CONV_AVG: out_conv_avg_r <= q_lat;
            default:                out_enc_avg_r  <= q_lat;
          endcase
          if (job_r == fpsm_pkg::JOB_ENC_AVG) begin
            state_r <= S_DONE;
          end else begin
            job_r   <= job_r + 3'd1;
            state_r <= S_LOAD;
          end
        end

        S_DONE: begin
          out_valid_r       <= 1'b1;
          out_enc_frames_r  <= encoded_count_r;
          out_dup_frames_r  <= dup_count_r;
          out_skip_frames_r <= skip_count_r;
          out_wait_peak_r   <= wait_max_r;
          out_last_seq_r    <= prev_enc_seq_r;
          // new interval
          interval_start_r  <= now_r;
          prev_cap_seq_r    <= cap_r;
          encoded_count_r   <= '0;
          dup_count_r       <= '0;
          skip_count_r      <= '0;
          wait_sum_r        <= '0;
          wait_max_r        <= '0;
          conv_sum_r        <= '0;
          enc_sum_r         <= '0;
          state_r           <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_capture_rate       = out_cap_rate_r;
  assign out_encode_rate        = out_enc_rate_r;
  assign out_captured_frames    = out_cap_frames_r;
  assign out_encoded_frames     = out_enc_frames_r;
  assign out_duplicate_frames   = out_dup_frames_r;
  assign out_skipped_frames     = out_skip_frames_r;
  assign out_wait_avg_us        = out_wait_avg_r;
  assign out_wait_peak_us       = out_wait_peak_r;
  assign out_convert_avg_us     = out_conv_avg_r;
  assign out_encode_avg_us      = out_enc_avg_r;
  assign out_latest_encoded_seq = out_last_seq_r;

endmodule

`default_nettype wire
